### hw/rtl/quaternion_to_euler_angles_top_defines.svh
// assertion helper macros for the quaternion to euler block
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH

// property checked on every edge outside reset
`define Q2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every edge, reset included
`define Q2E_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// shared widths, constants and arctangent table of the quaternion to euler block
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

  // fixed field widths
  localparam int unsigned QW = 16;
  localparam int unsigned AW = 16;
  // datapath width of the cordic x/y (values up to 2^31)
  localparam int unsigned CW = 34;
  // angle accumulator width, 2^-16 degree units (|z| < 2^27)
  localparam int unsigned ZW = 30;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned CORDIC_STAGES_MAX = 24;

  localparam logic signed [ZW-1:0] HALF_16 = ZW'(180 * 65536);
  localparam logic signed [AW-1:0] QUARTER_128 = AW'(11520);

  // pole classification codes
  localparam logic [1:0] POLE_NONE  = 2'd0;
  localparam logic [1:0] POLE_NORTH = 2'd1;
  localparam logic [1:0] POLE_SOUTH = 2'd2;

  // arctangent of 2^-i in 2^-16 degree, rounded
  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = ZW'(2949120);  1: r = ZW'(1740967);  2: r = ZW'(919879);
      3: r = ZW'(466945);   4: r = ZW'(234379);   5: r = ZW'(117304);
      6: r = ZW'(58666);    7: r = ZW'(29335);    8: r = ZW'(14668);
      9: r = ZW'(7334);     10: r = ZW'(3667);    11: r = ZW'(1833);
      12: r = ZW'(917);     13: r = ZW'(458);     14: r = ZW'(229);
      15: r = ZW'(115);     16: r = ZW'(57);      17: r = ZW'(29);
      18: r = ZW'(14);      19: r = ZW'(7);       20: r = ZW'(4);
      21: r = ZW'(2);       22: r = ZW'(1);       default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/quaternion_to_euler_angles_top.sv
// throughput: one item per cycle; a stall freezes the whole pipeline
// the bit-serial square root (one result bit per stage) sets the depth
// reset: asynchronous active low, clears all valid bits; payload is not reset
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// quaternion to pitch/yaw/roll in 1/128 degree with pole detection
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles_top
  import q2e_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [QW-1:0] quat_x_i,
  input  wire logic signed [QW-1:0] quat_y_i,
  input  wire logic signed [QW-1:0] quat_z_i,
  input  wire logic signed [QW-1:0] quat_w_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [AW-1:0]      pitch_deg_o,
  output logic signed [AW-1:0]      yaw_deg_o,
  output logic signed [AW-1:0]      roll_deg_o,
  output logic [1:0]                pole_case_o
);

  `include "quaternion_to_euler_angles_top_defines.svh"

  localparam int unsigned PW = 34;       // products and sums, |v| < 2^33
  localparam int unsigned RB = 29;       // square root result bits
  localparam int unsigned RW = 58;       // radicand width

  typedef struct packed {
    logic [1:0] pole;
    logic       negyaw;
  } ctl_t;

  // whole pipeline advances when the output register can take an item
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // stage 1: products
  logic              v1_q;
  logic signed [PW-1:0] sqx_q, sqy_q, sqz_q, sqw_q, xw_q, yz_q, wy_q, zx_q, wz_q, xy_q;
  logic signed [QW-1:0] x1_q, y1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= PW'(quat_x_i * quat_x_i);
      sqy_q <= PW'(quat_y_i * quat_y_i);
      sqz_q <= PW'(quat_z_i * quat_z_i);
      sqw_q <= PW'(quat_w_i * quat_w_i);
      xw_q  <= PW'(quat_x_i * quat_w_i);
      yz_q  <= PW'(quat_y_i * quat_z_i);
      wy_q  <= PW'(quat_w_i * quat_y_i);
      zx_q  <= PW'(quat_z_i * quat_x_i);
      wz_q  <= PW'(quat_w_i * quat_z_i);
      xy_q  <= PW'(quat_x_i * quat_y_i);
      x1_q  <= quat_x_i;
      y1_q  <= quat_y_i;
    end
  end

  // stage 2: sums
  logic              v2_q;
  logic signed [PW-1:0] unit_q, test_q, yy_q, yx_q, ry_q, rx_q;
  logic signed [QW-1:0] x2_q, y2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      unit_q <= sqx_q + sqy_q + sqz_q + sqw_q;
      test_q <= xw_q - yz_q;
      yy_q   <= (wy_q + zx_q) <<< 1;
      yx_q   <= PW'(1 <<< 28) - ((sqx_q + sqy_q) <<< 1);
      ry_q   <= (wz_q + xy_q) <<< 1;
      rx_q   <= PW'(1 <<< 28) - ((sqz_q + sqx_q) <<< 1);
      x2_q   <= x1_q;
      y2_q   <= y1_q;
    end
  end

  // stage 3: pole test products (constant multiplies) and saturated sine
  localparam int unsigned MW = 46;
  logic              v3_q;
  logic signed [MW-1:0] t2000_q, u999_q;
  logic signed [PW-1:0] s3_q, yy3_q, yx3_q, ry3_q, rx3_q;
  logic signed [QW-1:0] x3_q, y3_q;
  logic signed [PW-1:0] s_sat;
  always_comb begin
    s_sat = test_q <<< 1;
    if (s_sat > PW'(1 <<< 28)) s_sat = PW'(1 <<< 28);
    if (s_sat < -PW'(1 <<< 28)) s_sat = -PW'(1 <<< 28);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      t2000_q <= MW'(test_q) * MW'(2000);
      u999_q  <= MW'(unit_q) * MW'(999);
      s3_q    <= s_sat;
      yy3_q   <= yy_q;
      yx3_q   <= yx_q;
      ry3_q   <= ry_q;
      rx3_q   <= rx_q;
      x3_q    <= x2_q;
      y3_q    <= y2_q;
    end
  end

  // stage 4: classification and 1 - s^2
  logic              v4_q;
  ctl_t              c4_q;
  logic [RW-1:0]     rad4_q;
  logic signed [PW-1:0] s4_q, yy4_q, yx4_q, ry4_q, rx4_q;
  logic signed [QW-1:0] x4_q, y4_q;
  logic signed [2*PW-1:0] ssq;
  assign ssq = s3_q * s3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (t2000_q > u999_q) c4_q <= '{pole: POLE_NORTH, negyaw: 1'b0};
      else if (t2000_q < -u999_q) c4_q <= '{pole: POLE_SOUTH, negyaw: 1'b1};
      else c4_q <= '{pole: POLE_NONE, negyaw: 1'b0};
      rad4_q <= RW'((64'sd1 <<< 56) - 64'(ssq));
      s4_q   <= s3_q;
      yy4_q  <= yy3_q;
      yx4_q  <= yx3_q;
      ry4_q  <= ry3_q;
      rx4_q  <= rx3_q;
      x4_q   <= x3_q;
      y4_q   <= y3_q;
    end
  end

  // bit-serial square root, one result bit per stage
  logic [RW-1:0]     rem_q  [RB+1];
  logic [RB-1:0]     root_q [RB+1];
  ctl_t              cq_q   [RB+1];
  logic signed [PW-1:0] sq_q [RB+1], a_q [RB+1], b_q [RB+1], c_q [RB+1], d_q [RB+1];
  logic signed [QW-1:0] xq_q [RB+1], yq_q [RB+1];
  logic [RB:0]       vq_q;

  always_comb begin
    rem_q[0]  = rad4_q;
    root_q[0] = '0;
    cq_q[0]   = c4_q;
    sq_q[0]   = s4_q;
    a_q[0]    = yy4_q;
    b_q[0]    = yx4_q;
    c_q[0]    = ry4_q;
    d_q[0]    = rx4_q;
    xq_q[0]   = x4_q;
    yq_q[0]   = y4_q;
    vq_q[0]   = v4_q;
  end

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam int unsigned P = RB - 1 - k;
    logic [RW+1:0] trial;
    logic [RW+1:0] part;
    assign part  = {2'b00, rem_q[k]} >> (2 * P);
    assign trial = {({2'b00, root_q[k]}), 2'b01};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq_q[k+1] <= 1'b0;
      end else if (en) begin
        vq_q[k+1] <= vq_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (part >= (RW+2)'(trial)) begin
          rem_q[k+1]  <= rem_q[k] - RW'((RW+2)'(trial) << (2 * P));
          root_q[k+1] <= {root_q[k][RB-2:0], 1'b1};
        end else begin
          rem_q[k+1]  <= rem_q[k];
          root_q[k+1] <= {root_q[k][RB-2:0], 1'b0};
        end
        cq_q[k+1] <= cq_q[k];
        sq_q[k+1] <= sq_q[k];
        a_q[k+1]  <= a_q[k];
        b_q[k+1]  <= b_q[k];
        c_q[k+1]  <= c_q[k];
        d_q[k+1]  <= d_q[k];
        xq_q[k+1] <= xq_q[k];
        yq_q[k+1] <= yq_q[k];
      end
    end
  end

  // cordic operand selection: only the yaw unit's operands depend on pole case
  ctl_t cs;
  logic pole_any;
  logic signed [CW-1:0] p_y, p_x, y_y, y_x, r_y, r_x;
  always_comb begin
    cs       = cq_q[RB];
    pole_any = (cs.pole != POLE_NONE);
    p_y = CW'(sq_q[RB]);
    p_x = CW'({1'b0, root_q[RB]});
    y_y = pole_any ? CW'(yq_q[RB]) : CW'(a_q[RB]);
    y_x = pole_any ? CW'(xq_q[RB]) : CW'(b_q[RB]);
    r_y = CW'(c_q[RB]);
    r_x = CW'(d_q[RB]);
  end

  logic              pv, yv, rv;
  logic signed [ZW-1:0] pz, yz, rz;
  logic [2:0]        pt, yt, rt;

  q2e_cordic #(.Stages(CORDIC_STAGES), .TagW(3)) u_pitch (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vq_q[RB]), .y_i(p_y), .x_i(p_x),
    .tag_i({cs.pole, cs.negyaw}), .valid_o(pv), .z_o(pz), .tag_o(pt)
  );
  q2e_cordic #(.Stages(CORDIC_STAGES), .TagW(3)) u_yaw (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vq_q[RB]), .y_i(y_y), .x_i(y_x),
    .tag_i({cs.pole, cs.negyaw}), .valid_o(yv), .z_o(yz), .tag_o(yt)
  );
  q2e_cordic #(.Stages(CORDIC_STAGES), .TagW(3)) u_roll (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vq_q[RB]), .y_i(r_y), .x_i(r_x),
    .tag_i({cs.pole, cs.negyaw}), .valid_o(rv), .z_o(rz), .tag_o(rt)
  );

  // angle to 1/128 degree with wrap into [-180, 180)
  function automatic logic signed [AW-1:0] to_out(input logic signed [ZW+1:0] a);
    logic signed [ZW+1:0] v;
    v = (a + (ZW+2)'(256)) >>> 9;
    if (v >= (ZW+2)'(23040)) v = v - (ZW+2)'(46080);
    if (v < -(ZW+2)'(23040)) v = v + (ZW+2)'(46080);
    return AW'(v);
  endfunction

  logic [1:0]        pole_f;
  logic signed [ZW+1:0] yaw_a;
  always_comb begin
    pole_f = yt[2:1];
    yaw_a  = (ZW+2)'(yz);
    if (pole_f != POLE_NONE) yaw_a = yt[0] ? -(yaw_a <<< 1) : (yaw_a <<< 1);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= yv;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pole_case_o <= pole_f;
      yaw_deg_o   <= to_out(yaw_a);
      if (pole_f == POLE_NORTH) begin
        pitch_deg_o <= QUARTER_128;
        roll_deg_o  <= '0;
      end else if (pole_f == POLE_SOUTH) begin
        pitch_deg_o <= -QUARTER_128;
        roll_deg_o  <= '0;
      end else begin
        pitch_deg_o <= to_out((ZW+2)'(pz));
        roll_deg_o  <= to_out((ZW+2)'(rz));
      end
    end
  end

  // front stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // the three cordic units run in lockstep
  `Q2E_ASSERT(a_lockstep, (pv == yv) && (yv == rv), "cordic valid bits diverge")
  `Q2E_ASSERT(a_tag_match, !yv || ((pt == yt) && (rt == yt)), "cordic tags diverge")
  `Q2E_ASSERT(a_pole_code, !out_valid_o || (pole_case_o == POLE_NONE) || (pole_case_o == POLE_NORTH) || (pole_case_o == POLE_SOUTH), "bad pole code")
  `Q2E_ASSERT(a_hold, (out_valid_o && out_stall_i) |=> $stable(yaw_deg_o), "stalled result moved")

endmodule

`default_nettype wire

### hw/rtl/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic: atan2(y, x) in 2^-16 degree, one stage per
// iteration after a pre-rotation and normalization stage
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic
  import q2e_pkg::*;
#(
  parameter int unsigned Stages = CORDIC_STAGES_DEF,
  parameter int unsigned TagW = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic [TagW-1:0]      tag_i,
  output logic                      valid_o,
  output logic signed [ZW-1:0]      z_o,
  output logic [TagW-1:0]           tag_o
);

  localparam int unsigned NS = (Stages < CORDIC_STAGES_MAX) ? Stages : CORDIC_STAGES_MAX;
  localparam int unsigned SW = $clog2(CW + 1);

  // pre-rotation into the right half plane
  logic signed [CW-1:0] px, py;
  logic signed [ZW-1:0] pz;
  logic                 zero;
  logic [CW-1:0]        ax, ay, m;
  always_comb begin
    zero = (x_i == '0) && (y_i == '0);
    px = x_i;
    py = y_i;
    pz = '0;
    if (x_i < 0) begin
      px = -x_i;
      py = -y_i;
      pz = (-y_i <= 0) ? HALF_16 : -HALF_16;
    end
    ax = px[CW-1] ? CW'(-px) : CW'(px);
    ay = py[CW-1] ? CW'(-py) : CW'(py);
    m  = (ax > ay) ? ax : ay;
  end

  // normalization shift: bring max magnitude into [2^29, 2^30)
  logic        rsh;
  logic        found;
  logic [SW-1:0] sh;
  always_comb begin
    rsh   = 1'b0;
    found = 1'b0;
    sh    = '0;
    for (int b = CW - 1; b >= 0; b--) begin
      if (m[b] && !found) begin
        found = 1'b1;
        if (b >= 30) begin
          rsh = 1'b1;
          sh  = SW'(b - 29);
        end else begin
          sh  = SW'(29 - b);
        end
      end
    end
  end

  logic signed [CW-1:0] nx, ny;
  always_comb begin
    if (rsh) begin
      nx = px >>> sh;
      ny = py >>> sh;
    end else begin
      nx = px <<< sh;
      ny = py <<< sh;
    end
  end

  // stage registers: index 0 is the normalized entry
  logic signed [CW-1:0] x_q [NS+1];
  logic signed [CW-1:0] y_q [NS+1];
  logic signed [ZW-1:0] z_q [NS+1];
  logic [TagW-1:0]      t_q [NS+1];
  logic [NS:0]          v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-1:0], valid_i};
    end
  end

  // entry stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= zero ? '0 : nx;
      y_q[0] <= zero ? '0 : ny;
      z_q[0] <= zero ? '0 : pz;
      t_q[0] <= tag_i;
    end
  end

  // micro-rotation stages
  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[i+1] <= t_q[i];
        if (x_q[i] == '0 && y_q[i] == '0) begin
          x_q[i+1] <= '0;
          y_q[i+1] <= '0;
          z_q[i+1] <= z_q[i];
        end else if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_tab(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_tab(i);
        end
      end
    end
  end

  assign valid_o = v_q[NS];
  assign z_o     = z_q[NS];
  assign tag_o   = t_q[NS];

endmodule

`default_nettype wire
